>>> rtl/sdoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdoc_pkg
// Shared types and constants of the still-detect offset calibrator.
// ----------------------------------------------------------------------------
package sdoc_pkg;

  localparam int SAMPLE_COUNT = 1000;
  localparam int NUM_AXES     = 3;
  localparam int NUM_SLOTS    = 6;
  localparam int SAMPLE_W     = 16;
  localparam int CNT_W        = $clog2(SAMPLE_COUNT);
  localparam int SUM_W        = SAMPLE_W + CNT_W + 1;
  localparam int QUO_W        = 16;
  localparam int CORR_W       = 18;
  localparam int TOTAL_W      = 19;
  localparam int MEAN_SHIFT   = 32768;
  localparam int DIV_BIAS     = SAMPLE_COUNT * MEAN_SHIFT + SAMPLE_COUNT / 2;
  localparam int SAT_MAX      = 32767;
  localparam int SAT_MIN      = -32768;

  // The biased sum is divided by SAMPLE_COUNT as a shift right by three
  // followed by a multiply with ceil(2^30 / 125) and a shift right by 30.
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIV_IN_W      = 23;
  localparam int RECIP_W       = 24;
  localparam int RECIP_MULT    = 8589935;
  localparam int RECIP_SHIFT   = 30;
  localparam int PROD_W        = DIV_IN_W + RECIP_W;

  localparam int SLOT_W         = 3;
  localparam int GYRO_SLOT_BASE = 3;
  localparam int AXIS_W         = 2;
  localparam int LAST_AXIS      = NUM_AXES - 1;
  localparam int ACCEL_Z_AXIS   = 2;
  localparam int MAX_PHYS_AXIS  = 2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_SENSOR_KIND = 2'd0;
  localparam logic [1:0] REG_MOTION_TOL  = 2'd1;
  localparam logic [1:0] REG_SLOT_MAP    = 2'd2;
  localparam logic [1:0] REG_SIGN_MAP    = 2'd3;

  localparam logic [15:0] MOTION_TOL_RST = 16'd64;
  localparam logic [5:0]  SLOT_MAP_RST   = 6'd33;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_OFFSET = 1'b1;

  localparam logic SENSOR_GYRO  = 1'b0;
  localparam logic SENSOR_ACCEL = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CORR_W-1:0]   corr_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [AXIS_W-1:0]          axis_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEED,
    PH_COLLECT
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic seed;
    logic commit;
    logic load;
    logic step;
  } lane_ctl_t;

  typedef struct packed {
    logic  we;
    axis_t axis;
  } offs_ctl_t;

endpackage

>>> rtl/sdoc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdoc_in_if / sdoc_out_if
// Request channels of the calibrator: samples and commands in, results out.
// ----------------------------------------------------------------------------
interface sdoc_in_if;
  logic             valid;
  logic             ready;
  logic             cmd;
  sdoc_pkg::sample_t sample_x;
  sdoc_pkg::sample_t sample_y;
  sdoc_pkg::sample_t sample_z;

  modport source (output valid, output cmd, output sample_x, output sample_y,
                  output sample_z, input ready);
  modport sink   (input valid, input cmd, input sample_x, input sample_y,
                  input sample_z, output ready);
endinterface

interface sdoc_out_if;
  logic              valid;
  logic              ready;
  logic              result_kind;
  sdoc_pkg::slot_t   offset_slot;
  sdoc_pkg::sample_t offset_value;
  logic              last;

  modport source (output valid, output result_kind, output offset_slot,
                  output offset_value, output last, input ready);
  modport sink   (input valid, input result_kind, input offset_slot,
                  input offset_value, input last, output ready);
endinterface

>>> rtl/sdoc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdoc_lane
// One axis lane: motion check against the previous sample, running sum, and a
// reciprocal multiplier that turns the finished sum into a rounded correction.
// ----------------------------------------------------------------------------
module sdoc_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  sdoc_pkg::lane_ctl_t ctl,
  input  sdoc_pkg::sample_t   sample,
  input  logic [15:0]         tolerance,
  input  logic                negate,
  output logic                moved,
  output sdoc_pkg::corr_t     corr
);

  sdoc_pkg::sample_t                       prev_r, prev_nxt;
  logic signed [sdoc_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [sdoc_pkg::DIV_IN_W-1:0]           div_r, div_nxt;
  logic [sdoc_pkg::QUO_W-1:0]              quo_r, quo_nxt;

  logic signed [16:0]                      diff;
  logic [16:0]                             abs_diff;
  logic signed [sdoc_pkg::SUM_W-1:0]       new_sum;
  logic signed [sdoc_pkg::SUM_W:0]         biased;
  logic [sdoc_pkg::PROD_W-1:0]             product;
  sdoc_pkg::corr_t                         corr_raw;

  always_comb begin
    diff     = {prev_r[15], prev_r} - {sample[15], sample};
    abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
    moved    = abs_diff > {1'b0, tolerance};
    new_sum  = sum_r + sdoc_pkg::SUM_W'(sample);
    biased   = $signed({new_sum[sdoc_pkg::SUM_W-1], new_sum})
               + $signed((sdoc_pkg::SUM_W + 1)'(sdoc_pkg::DIV_BIAS));
    product  = div_r * sdoc_pkg::RECIP_W'(sdoc_pkg::RECIP_MULT);
  end

  always_comb begin
    prev_nxt = prev_r;
    sum_nxt  = sum_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (ctl.seed) begin
      prev_nxt = sample;
      sum_nxt  = '0;
    end
    if (ctl.commit) begin
      prev_nxt = sample;
      sum_nxt  = new_sum;
    end
    if (ctl.load) begin
      sum_nxt = '0;
      div_nxt = biased[sdoc_pkg::DIV_PRE_SHIFT +: sdoc_pkg::DIV_IN_W];
    end
    if (ctl.step) begin
      quo_nxt = product[sdoc_pkg::RECIP_SHIFT +: sdoc_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      sum_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    corr_raw = $signed({2'b00, quo_r}) - $signed(sdoc_pkg::CORR_W'(sdoc_pkg::MEAN_SHIFT));
    corr     = negate ? -corr_raw : corr_raw;
  end

endmodule

>>> rtl/sdoc_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdoc_offset
// Merge stage: maps each logical axis to its physical slot and applies the lane
// corrections, one axis per cycle with we set, to saturating stored offsets.
// ----------------------------------------------------------------------------
module sdoc_offset (
  input  logic                clk,
  input  logic                rst_n,
  input  sdoc_pkg::offs_ctl_t ctl,
  input  sdoc_pkg::corr_t     corr [sdoc_pkg::NUM_AXES],
  input  logic                sensor_kind,
  input  logic [5:0]          slot_map,
  output sdoc_pkg::slot_t     slot,
  output sdoc_pkg::sample_t   value
);

  sdoc_pkg::sample_t                   stored_r [sdoc_pkg::NUM_SLOTS];
  logic [1:0]                          phys;
  logic [1:0]                          phys_raw;
  logic signed [sdoc_pkg::TOTAL_W-1:0] total;
  sdoc_pkg::corr_t                     corr_sel;

  always_comb begin
    phys_raw = slot_map[{ctl.axis, 1'b0} +: 2];
    phys     = (phys_raw > 2'(sdoc_pkg::MAX_PHYS_AXIS)) ? 2'(sdoc_pkg::MAX_PHYS_AXIS) : phys_raw;
    slot     = (sensor_kind == sdoc_pkg::SENSOR_ACCEL)
               ? sdoc_pkg::SLOT_W'(phys)
               : sdoc_pkg::SLOT_W'(phys) + sdoc_pkg::SLOT_W'(sdoc_pkg::GYRO_SLOT_BASE);
    case (ctl.axis)
      2'd0:    corr_sel = corr[0];
      2'd1:    corr_sel = corr[1];
      default: corr_sel = corr[2];
    endcase
    total = sdoc_pkg::TOTAL_W'(stored_r[slot]) + sdoc_pkg::TOTAL_W'(corr_sel);
    if (sensor_kind == sdoc_pkg::SENSOR_ACCEL && ctl.axis == 2'(sdoc_pkg::ACCEL_Z_AXIS)) begin
      value = '0;
    end else if (total > sdoc_pkg::TOTAL_W'(sdoc_pkg::SAT_MAX)) begin
      value = 16'(sdoc_pkg::SAT_MAX);
    end else if (total < sdoc_pkg::TOTAL_W'(sdoc_pkg::SAT_MIN)) begin
      value = 16'(sdoc_pkg::SAT_MIN);
    end else begin
      value = total[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sdoc_pkg::NUM_SLOTS; i++) begin
        stored_r[i] <= '0;
      end
    end else if (ctl.we) begin
      stored_r[slot] <= value;
    end
  end

endmodule

>>> rtl/still_detect_offset_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// still_detect_offset_calibrator
// Arms on a start request, checks each sample for motion in three parallel
// axis lanes, and on a full still run updates the stored offsets.
// ----------------------------------------------------------------------------
// A motion result is registered in the cycle after its sample request.
// Throughput: one request per cycle while results are taken; the sample that
// completes a run holds the input through the reciprocal multiply and the three
// offset results, one per axis, paced by the shared offset merge stage.
// Reset: synchronous active-low rst_n clears configuration to its defaults,
// the stored offsets to zero and the block to idle.
// ----------------------------------------------------------------------------
module still_detect_offset_calibrator (
  input  logic                    clk,
  input  logic                    rst_n,
  sdoc_in_if.sink                 in_ch,
  sdoc_out_if.source              out_ch,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [sdoc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sdoc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sdoc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                    cfg_pready
);

  logic        sensor_kind_r;
  logic [15:0] motion_tol_r;
  logic [5:0]  slot_map_r;
  logic [2:0]  sign_map_r;

  sdoc_pkg::phase_t      phase_r, phase_nxt;
  sdoc_pkg::ctrl_state_t state_r, state_nxt;
  logic [sdoc_pkg::CNT_W-1:0]  count_r, count_nxt;
  sdoc_pkg::axis_t             axis_r, axis_nxt;

  logic              out_valid_r;
  logic              out_kind_r;
  sdoc_pkg::slot_t   out_slot_r;
  sdoc_pkg::sample_t out_value_r;
  logic              out_last_r;

  logic                out_free;
  logic                accept;
  logic                any_moved;
  logic                run_done;
  logic                load_motion;
  logic                load_offset;
  logic                cfg_write;
  sdoc_pkg::lane_ctl_t lane_ctl;
  sdoc_pkg::offs_ctl_t offs_ctl;
  sdoc_pkg::sample_t   lane_sample [sdoc_pkg::NUM_AXES];
  logic                lane_moved  [sdoc_pkg::NUM_AXES];
  sdoc_pkg::corr_t     lane_corr   [sdoc_pkg::NUM_AXES];
  sdoc_pkg::slot_t     merge_slot;
  sdoc_pkg::sample_t   merge_value;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_kind_r <= sdoc_pkg::SENSOR_GYRO;
      motion_tol_r  <= sdoc_pkg::MOTION_TOL_RST;
      slot_map_r    <= sdoc_pkg::SLOT_MAP_RST;
      sign_map_r    <= '0;
    end else if (cfg_write) begin
      case (cfg_paddr[3:2])
        sdoc_pkg::REG_SENSOR_KIND: sensor_kind_r <= cfg_pwdata[0];
        sdoc_pkg::REG_MOTION_TOL:  motion_tol_r  <= cfg_pwdata[15:0];
        sdoc_pkg::REG_SLOT_MAP:    slot_map_r    <= cfg_pwdata[5:0];
        sdoc_pkg::REG_SIGN_MAP:    sign_map_r    <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      sdoc_pkg::REG_SENSOR_KIND: cfg_prdata = sdoc_pkg::CFG_DATA_W'(sensor_kind_r);
      sdoc_pkg::REG_MOTION_TOL:  cfg_prdata = sdoc_pkg::CFG_DATA_W'(motion_tol_r);
      sdoc_pkg::REG_SLOT_MAP:    cfg_prdata = sdoc_pkg::CFG_DATA_W'(slot_map_r);
      sdoc_pkg::REG_SIGN_MAP:    cfg_prdata = sdoc_pkg::CFG_DATA_W'(sign_map_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Axis lanes.
  assign lane_sample[0] = in_ch.sample_x;
  assign lane_sample[1] = in_ch.sample_y;
  assign lane_sample[2] = in_ch.sample_z;

  for (genvar g = 0; g < sdoc_pkg::NUM_AXES; g++) begin : g_lane
    sdoc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (lane_ctl),
      .sample    (lane_sample[g]),
      .tolerance (motion_tol_r),
      .negate    (sign_map_r[g]),
      .moved     (lane_moved[g]),
      .corr      (lane_corr[g])
    );
  end

  sdoc_offset u_offset (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (offs_ctl),
    .corr        (lane_corr),
    .sensor_kind (sensor_kind_r),
    .slot_map    (slot_map_r),
    .slot        (merge_slot),
    .value       (merge_value)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign any_moved = lane_moved[0] || lane_moved[1] || lane_moved[2];
  assign run_done  = count_r == sdoc_pkg::CNT_W'(sdoc_pkg::SAMPLE_COUNT - 1);
  assign accept    = in_ch.valid && in_ch.ready;

  // Control outputs.
  always_comb begin
    in_ch.ready     = 1'b0;
    lane_ctl        = '0;
    offs_ctl.we     = 1'b0;
    offs_ctl.axis   = axis_r;
    load_motion     = 1'b0;
    load_offset     = 1'b0;
    case (state_r)
      sdoc_pkg::ST_RUN: begin
        in_ch.ready = out_free;
        if (accept && in_ch.cmd == sdoc_pkg::CMD_SAMPLE) begin
          if (phase_r == sdoc_pkg::PH_SEED) begin
            lane_ctl.seed = 1'b1;
          end else if (phase_r == sdoc_pkg::PH_COLLECT) begin
            if (any_moved) begin
              load_motion = 1'b1;
            end else begin
              lane_ctl.commit = 1'b1;
              lane_ctl.load   = run_done;
            end
          end
        end
      end
      sdoc_pkg::ST_DIVIDE: begin
        lane_ctl.step = 1'b1;
      end
      sdoc_pkg::ST_EMIT: begin
        if (out_free) begin
          offs_ctl.we = 1'b1;
          load_offset = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    axis_nxt  = axis_r;
    case (state_r)
      sdoc_pkg::ST_RUN: begin
        if (accept) begin
          if (in_ch.cmd == sdoc_pkg::CMD_START) begin
            phase_nxt = sdoc_pkg::PH_SEED;
          end else if (phase_r == sdoc_pkg::PH_SEED) begin
            phase_nxt = sdoc_pkg::PH_COLLECT;
            count_nxt = '0;
          end else if (phase_r == sdoc_pkg::PH_COLLECT) begin
            if (any_moved) begin
              phase_nxt = sdoc_pkg::PH_SEED;
            end else if (run_done) begin
              phase_nxt = sdoc_pkg::PH_IDLE;
              count_nxt = '0;
              state_nxt = sdoc_pkg::ST_DIVIDE;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
      end
      sdoc_pkg::ST_DIVIDE: begin
        axis_nxt  = '0;
        state_nxt = sdoc_pkg::ST_EMIT;
      end
      sdoc_pkg::ST_EMIT: begin
        if (out_free) begin
          axis_nxt = axis_r + 1'b1;
          if (axis_r == sdoc_pkg::AXIS_W'(sdoc_pkg::LAST_AXIS)) begin
            state_nxt = sdoc_pkg::ST_RUN;
          end
        end
      end
      default: state_nxt = sdoc_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdoc_pkg::ST_RUN;
      phase_r     <= sdoc_pkg::PH_IDLE;
      count_r     <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      axis_r  <= axis_nxt;
      if (load_motion || load_offset) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_motion) begin
      out_kind_r  <= sdoc_pkg::KIND_MOTION;
      out_slot_r  <= '0;
      out_value_r <= '0;
      out_last_r  <= 1'b1;
    end else if (load_offset) begin
      out_kind_r  <= sdoc_pkg::KIND_OFFSET;
      out_slot_r  <= merge_slot;
      out_value_r <= merge_value;
      out_last_r  <= axis_r == sdoc_pkg::AXIS_W'(sdoc_pkg::LAST_AXIS);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.offset_slot  = out_slot_r;
  assign out_ch.offset_value = out_value_r;
  assign out_ch.last         = out_last_r;

endmodule
